// ===== rtl/core/ppt2d_pkg.sv =====
package ppt2d_pkg;
	localparam int CoordWidth = 32;
	localparam int FracBits = 16;
	localparam int CoefWidth = 32;
	localparam int CfgWidth = 64;
	localparam int IdxWidth = 3;
	localparam int ProdWidth = CoefWidth + CoordWidth;
	localparam int SumWidth = ProdWidth + 2;
	localparam int NumWidth = SumWidth + FracBits;
	localparam int QuoWidth = NumWidth;
	localparam int NumCells = QuoWidth;
	localparam int CntWidth = $clog2(NumCells + 1);

	typedef enum logic [IdxWidth-1:0] {
		REG_COL0 = 3'd0,
		REG_COL1 = 3'd1,
		REG_TRANS = 3'd2,
		REG_PERSP = 3'd3,
		REG_WBIAS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_WZERO = 2'd1,
		ST_CLAMP = 2'd2
	} status_t;

	typedef struct packed {
		logic [NumWidth-1:0] rem_x;
		logic [NumWidth-1:0] rem_y;
		logic [QuoWidth-1:0] quo_x;
		logic [QuoWidth-1:0] quo_y;
		logic [NumWidth-1:0] num_x;
		logic [NumWidth-1:0] num_y;
		logic [NumWidth-1:0] den;
		logic neg_x;
		logic neg_y;
		logic wzero;
	} div_slot_t;
endpackage

// ===== rtl/core/projective_point_transform_2d.sv =====
// channel   | signals                         | transfer
// ----------+---------------------------------+--------------------------
// config    | cfg_we, cfg_index, cfg_data     | cfg_we high at clk edge
// point in  | start, busy, x_in, y_in         | start high, busy low
// result    | done, x_out, y_out, status      | done high, one cycle
// one point per cycle; each point passes the front stages, then one restoring
// divide cell per quotient bit (ppt2d_pkg::NumCells), then the output register
// busy is always low; points overlap freely in the front and the divide chain
// arst_n clears all valid bits and loads the identity matrix
// results cannot be stalled; done pulses for exactly one cycle per point
module projective_point_transform_2d (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [ppt2d_pkg::CoordWidth-1:0] x_in,
	input  logic signed [ppt2d_pkg::CoordWidth-1:0] y_in,
	input  logic cfg_we,
	input  logic [ppt2d_pkg::IdxWidth-1:0] cfg_index,
	input  logic [ppt2d_pkg::CfgWidth-1:0] cfg_data,
	output logic done,
	output logic signed [ppt2d_pkg::CoordWidth-1:0] x_out,
	output logic signed [ppt2d_pkg::CoordWidth-1:0] y_out,
	output logic [1:0] status
);
	localparam int N = ppt2d_pkg::NumCells;
	localparam int QW = ppt2d_pkg::QuoWidth;
	localparam int CDW = ppt2d_pkg::CoordWidth;

	logic [ppt2d_pkg::CfgWidth-1:0] col0_q, col1_q, trans_q, persp_q;
	logic [ppt2d_pkg::CoefWidth-1:0] wbias_q;
	logic v [N+1];
	ppt2d_pkg::div_slot_t sl [N+1];
	logic [QW-1:0] lim_x, lim_y, mag_x, mag_y;
	logic cl_x, cl_y;
	ppt2d_pkg::div_slot_t f;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q <= 64'h0000_0000_0001_0000;
			col1_q <= 64'h0001_0000_0000_0000;
			trans_q <= '0;
			persp_q <= '0;
			wbias_q <= 32'h0001_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				ppt2d_pkg::REG_COL0: col0_q <= cfg_data;
				ppt2d_pkg::REG_COL1: col1_q <= cfg_data;
				ppt2d_pkg::REG_TRANS: trans_q <= cfg_data;
				ppt2d_pkg::REG_PERSP: persp_q <= cfg_data;
				ppt2d_pkg::REG_WBIAS: wbias_q <= cfg_data[ppt2d_pkg::CoefWidth-1:0];
				default: ;
			endcase
		end
	end

	ppt2d_front u_front (
		.clk(clk), .arst_n(arst_n), .go(start && !busy), .x_in(x_in), .y_in(y_in),
		.col0_q(col0_q), .col1_q(col1_q), .trans_q(trans_q), .persp_q(persp_q),
		.wbias_q(wbias_q), .valid_out(v[0]), .slot_out(sl[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		ppt2d_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .valid_in(v[i]), .slot_in(sl[i]),
			.valid_out(v[i+1]), .slot_out(sl[i+1])
		);
	end

	always_comb begin
		f = sl[N];
		lim_x = f.neg_x ? QW'(1) << (CDW-1) : (QW'(1) << (CDW-1)) - QW'(1);
		lim_y = f.neg_y ? QW'(1) << (CDW-1) : (QW'(1) << (CDW-1)) - QW'(1);
		cl_x = f.quo_x > lim_x;
		cl_y = f.quo_y > lim_y;
		mag_x = cl_x ? lim_x : f.quo_x;
		mag_y = cl_y ? lim_y : f.quo_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (f.wzero) begin
			x_out <= '0;
			y_out <= '0;
			status <= ppt2d_pkg::ST_WZERO;
		end else begin
			x_out <= f.neg_x ? CDW'(-mag_x) : CDW'(mag_x);
			y_out <= f.neg_y ? CDW'(-mag_y) : CDW'(mag_y);
			status <= (cl_x || cl_y) ? ppt2d_pkg::ST_CLAMP : ppt2d_pkg::ST_OK;
		end
	end

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3)) else $error("bad status");
	a_wzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ppt2d_pkg::ST_WZERO) |-> (x_out == '0 && y_out == '0))
		else $error("nonzero output on zero weight");
	a_front_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v[0] |-> $past(start, 3)) else $error("front valid without start");
endmodule

// ===== rtl/core/ppt2d_div_cell.sv =====
module ppt2d_div_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	input  ppt2d_pkg::div_slot_t slot_in,
	output logic valid_out,
	output ppt2d_pkg::div_slot_t slot_out
);
	localparam int W = ppt2d_pkg::NumWidth;
	logic [W:0] trial_x, trial_y;
	logic [W-1:0] shx, shy;
	ppt2d_pkg::div_slot_t nxt;

	always_comb begin
		nxt = slot_in;
		shx = {slot_in.rem_x[W-2:0], slot_in.num_x[W-1]};
		shy = {slot_in.rem_y[W-2:0], slot_in.num_y[W-1]};
		nxt.num_x = {slot_in.num_x[W-2:0], 1'b0};
		nxt.num_y = {slot_in.num_y[W-2:0], 1'b0};
		trial_x = {1'b0, shx} - {1'b0, slot_in.den};
		trial_y = {1'b0, shy} - {1'b0, slot_in.den};
		nxt.rem_x = trial_x[W] ? shx : trial_x[W-1:0];
		nxt.rem_y = trial_y[W] ? shy : trial_y[W-1:0];
		nxt.quo_x = {slot_in.quo_x[ppt2d_pkg::QuoWidth-2:0], ~trial_x[W]};
		nxt.quo_y = {slot_in.quo_y[ppt2d_pkg::QuoWidth-2:0], ~trial_y[W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		slot_out <= nxt;
	end
endmodule

// ===== rtl/core/ppt2d_front.sv =====
module ppt2d_front (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic signed [ppt2d_pkg::CoordWidth-1:0] x_in,
	input  logic signed [ppt2d_pkg::CoordWidth-1:0] y_in,
	input  logic [ppt2d_pkg::CfgWidth-1:0] col0_q,
	input  logic [ppt2d_pkg::CfgWidth-1:0] col1_q,
	input  logic [ppt2d_pkg::CfgWidth-1:0] trans_q,
	input  logic [ppt2d_pkg::CfgWidth-1:0] persp_q,
	input  logic [ppt2d_pkg::CoefWidth-1:0] wbias_q,
	output logic valid_out,
	output ppt2d_pkg::div_slot_t slot_out
);
	localparam int PW = ppt2d_pkg::ProdWidth;
	localparam int SW = ppt2d_pkg::SumWidth;
	localparam int NW = ppt2d_pkg::NumWidth;
	localparam int CW = ppt2d_pkg::CoefWidth;

	logic signed [PW-1:0] p_s1 [6];
	logic signed [CW-1:0] c_s1 [3];
	logic v_s1, v_s2;
	logic signed [SW-1:0] tx_s2, ty_s2, tw_s2;
	logic signed [SW-1:0] tx, ty, tw;
	logic [SW-1:0] mx, my, mw;
	ppt2d_pkg::div_slot_t s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= $signed(col0_q[CW-1:0]) * x_in;
		p_s1[1] <= $signed(col1_q[CW-1:0]) * y_in;
		p_s1[2] <= $signed(col0_q[2*CW-1:CW]) * x_in;
		p_s1[3] <= $signed(col1_q[2*CW-1:CW]) * y_in;
		p_s1[4] <= $signed(persp_q[CW-1:0]) * x_in;
		p_s1[5] <= $signed(persp_q[2*CW-1:CW]) * y_in;
		c_s1[0] <= $signed(trans_q[CW-1:0]);
		c_s1[1] <= $signed(trans_q[2*CW-1:CW]);
		c_s1[2] <= $signed(wbias_q);
		tx_s2 <= SW'(p_s1[0]) + SW'(p_s1[1])
			+ (SW'(c_s1[0]) <<< ppt2d_pkg::FracBits);
		ty_s2 <= SW'(p_s1[2]) + SW'(p_s1[3])
			+ (SW'(c_s1[1]) <<< ppt2d_pkg::FracBits);
		tw_s2 <= SW'(p_s1[4]) + SW'(p_s1[5])
			+ (SW'(c_s1[2]) <<< ppt2d_pkg::FracBits);
		slot_out <= s;
	end

	always_comb begin
		tx = tx_s2;
		ty = ty_s2;
		tw = tw_s2;
		mx = tx[SW-1] ? SW'(-tx) : SW'(tx);
		my = ty[SW-1] ? SW'(-ty) : SW'(ty);
		mw = tw[SW-1] ? SW'(-tw) : SW'(tw);
		s = '0;
		s.num_x = {mx, {ppt2d_pkg::FracBits{1'b0}}};
		s.num_y = {my, {ppt2d_pkg::FracBits{1'b0}}};
		s.den = NW'(mw);
		s.neg_x = tx[SW-1] ^ tw[SW-1];
		s.neg_y = ty[SW-1] ^ tw[SW-1];
		s.wzero = (tw == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= v_s2;
		end
	end
endmodule
